// ----- rtl/kera_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_pkg
// Shared types, codes and reset values for the key event repeat and aging
// block.
// ----------------------------------------------------------------------------
package kera_pkg;

    // opcode
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // input event class
    localparam logic [1:0] CLS_OTHER    = 2'd0;
    localparam logic [1:0] CLS_KEY_DOWN = 2'd1;
    localparam logic [1:0] CLS_KEY_UP   = 2'd2;

    // result status
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_DELIVERED = 2'd1;
    localparam logic [1:0] ST_EXPIRED   = 2'd2;

    // result class
    localparam logic [1:0] OUT_PASS   = 2'd0;
    localparam logic [1:0] OUT_REPEAT = 2'd1;
    localparam logic [1:0] OUT_NULL   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DELAY    = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;

    localparam logic [15:0] DELAY_RST    = 16'd500;
    localparam logic [15:0] INTERVAL_RST = 16'd50;
    localparam logic [15:0] LIFETIME_RST = 16'd3000;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  event_class;
        logic [15:0] event_code;
        logic [15:0] event_arg;
        logic [31:0] event_stamp;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  out_class;
        logic [15:0] out_code;
        logic [15:0] out_arg;
        logic [31:0] out_stamp;
        logic        push_repeat;
        logic [15:0] push_arg;
        logic [31:0] push_stamp;
    } out_item_t;

    typedef struct packed {
        logic [15:0] repeat_delay;
        logic [15:0] repeat_interval;
        logic [15:0] event_lifetime;
    } cfg_t;

endpackage

// ----- rtl/kera_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_regs
// Configuration registers: repeat delay, repeat interval, event lifetime.
// ----------------------------------------------------------------------------
module kera_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [15:0]         wr_data,
    output kera_pkg::cfg_t      cfg
);

    kera_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_delay    <= kera_pkg::DELAY_RST;
            cfg_reg.repeat_interval <= kera_pkg::INTERVAL_RST;
            cfg_reg.event_lifetime  <= kera_pkg::LIFETIME_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                kera_pkg::REG_DELAY:    cfg_reg.repeat_delay    <= wr_data;
                kera_pkg::REG_INTERVAL: cfg_reg.repeat_interval <= wr_data;
                kera_pkg::REG_LIFETIME: cfg_reg.event_lifetime  <= wr_data;
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/kera_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_engine
// Held-key state and the per-item decision: aging check, key tracking and
// the typematic repeat timer. State advances when an item is retired.
// ----------------------------------------------------------------------------
module kera_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  kera_pkg::in_item_t  item,
    input  kera_pkg::cfg_t      cfg,
    output kera_pkg::out_item_t result
);

    logic [15:0] held_key_reg,    held_key_next;
    logic        repeating_reg,   repeating_next;
    logic [31:0] press_stamp_reg, press_stamp_next;
    logic [31:0] last_rep_reg,    last_rep_next;

    logic [32:0] now_w;
    logic        live;
    logic        rep_due;
    logic        rep_start;
    logic        is_event;
    logic        do_tick;

    // all sums kept 33 bits wide so they never wrap
    assign now_w    = {1'b0, item.now_ms};
    assign live     = ({1'b0, item.event_stamp} + {17'd0, cfg.event_lifetime}) > now_w;
    assign rep_due  = repeating_reg
                      && (now_w >= ({1'b0, last_rep_reg} + {17'd0, cfg.repeat_interval}));
    assign rep_start = !repeating_reg && (held_key_reg != 16'd0)
                      && (now_w >= ({1'b0, press_stamp_reg} + {17'd0, cfg.repeat_delay}));
    assign is_event = (item.opcode == kera_pkg::OP_EVENT);
    assign do_tick  = !is_event
                      || (live && item.event_class != kera_pkg::CLS_KEY_DOWN
                               && item.event_class != kera_pkg::CLS_KEY_UP);

    always_comb
    begin
        held_key_next    = held_key_reg;
        repeating_next   = repeating_reg;
        press_stamp_next = press_stamp_reg;
        last_rep_next    = last_rep_reg;
        result           = '0;

        if (is_event)
        begin
            result.out_class = kera_pkg::OUT_PASS;
            result.out_code  = item.event_code;
            result.out_arg   = item.event_arg;
            result.out_stamp = item.event_stamp;
            if (live)
            begin
                result.status = kera_pkg::ST_DELIVERED;
                if (item.event_class == kera_pkg::CLS_KEY_DOWN)
                begin
                    held_key_next    = item.event_arg;
                    press_stamp_next = item.now_ms;
                    repeating_next   = 1'b0;
                end
                else if (item.event_class == kera_pkg::CLS_KEY_UP)
                begin
                    held_key_next  = 16'd0;
                    repeating_next = 1'b0;
                end
                else if (rep_due)
                begin
                    result.push_repeat = 1'b1;
                    result.push_arg    = held_key_reg;
                    result.push_stamp  = item.now_ms;
                end
            end
            else
            begin
                result.status = kera_pkg::ST_EXPIRED;
            end
        end
        else
        begin
            result.out_stamp = item.now_ms;
            if (rep_due)
            begin
                result.status    = kera_pkg::ST_DELIVERED;
                result.out_class = kera_pkg::OUT_REPEAT;
                result.out_arg   = held_key_reg;
            end
            else
            begin
                result.status    = kera_pkg::ST_NONE;
                result.out_class = kera_pkg::OUT_NULL;
            end
        end

        if (do_tick)
        begin
            if (rep_due)
            begin
                last_rep_next = item.now_ms;
            end
            else if (rep_start)
            begin
                last_rep_next  = item.now_ms;
                repeating_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg    <= '0;
            repeating_reg   <= 1'b0;
            press_stamp_reg <= '0;
            last_rep_reg    <= '0;
        end
        else if (fire)
        begin
            held_key_reg    <= held_key_next;
            repeating_reg   <= repeating_next;
            press_stamp_reg <= press_stamp_next;
            last_rep_reg    <= last_rep_next;
        end
    end

endmodule

// ----- rtl/key_event_repeat_and_aging.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_repeat_and_aging
// Typematic key repeat with event aging: input register, one pass of
// decision logic, result register.
// ----------------------------------------------------------------------------
// The input item is registered, decided and registered again as the result
// (input reg, result reg). Throughput: 1 item per cycle while out_ready is
// high; the held-key state updates once per item.
// The decision path is one 33-bit add and compare plus selection.
// Reset: rst_n clears the valid flags of both stages and the key state, and
// restores the configuration defaults (delay 500, interval 50, lifetime 3000).
// ----------------------------------------------------------------------------
module key_event_repeat_and_aging
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kera_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kera_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    kera_pkg::in_item_t  in_item_reg;
    logic                in_vld_reg;
    kera_pkg::out_item_t out_item_reg;
    logic                out_vld_reg;
    kera_pkg::out_item_t result;
    kera_pkg::cfg_t      cfg;
    logic                advance;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    kera_regs u_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kera_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

endmodule

// ----- rtl/kera_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_checker
// Port-level checks for key_event_repeat_and_aging, bound to the top level.
// ----------------------------------------------------------------------------
module kera_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input kera_pkg::out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // only a delivered pass-through item may request a push
    a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.push_repeat |->
            out_data.status == kera_pkg::ST_DELIVERED
            && out_data.out_class == kera_pkg::OUT_PASS)
        else $error("push requested on a non-delivered item");

    // null item carries no-event status and no push
    a_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_class == kera_pkg::OUT_NULL |->
            out_data.status == kera_pkg::ST_NONE && !out_data.push_repeat
            && out_data.out_arg == 16'd0)
        else $error("malformed null item");

    // repeat item: delivered, zero code, no push
    a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_class == kera_pkg::OUT_REPEAT |->
            out_data.status == kera_pkg::ST_DELIVERED && out_data.out_code == 16'd0
            && !out_data.push_repeat)
        else $error("malformed repeat item");

endmodule

bind key_event_repeat_and_aging kera_checker u_kera_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- dv/key_event_repeat_and_aging_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_repeat_and_aging_tb
// Self-checking bench for the typematic repeat and event aging block. A
// queue-fed driver sends event and poll items in random bursts. A scoreboard
// model predicts each result when its item is accepted, and a monitor with
// its own stall pattern checks every result field by field. The run covers
// the reset settings, all-zero and all-ones registers, and several random
// settings. Register writes happen only while the block is idle.
// ----------------------------------------------------------------------------
module key_event_repeat_and_aging_tb;

    import kera_pkg::*;

    localparam logic [1:0] CLS_RESERVED = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    key_event_repeat_and_aging DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Scoreboard copy of the registers and key state
    logic [15:0] delay_ms    = DELAY_RST;
    logic [15:0] interval_ms = INTERVAL_RST;
    logic [15:0] lifetime_ms = LIFETIME_RST;
    logic [15:0] key_held    = '0;
    logic        rpt_active  = 1'b0;
    logic [31:0] press_ms    = '0;
    logic [31:0] last_rpt_ms = '0;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];

    int err_count   = 0;
    int n_generated = 0;
    int n_accepted  = 0;
    int n_settings  = 1;
    int n_repeats   = 0;
    int n_pushes    = 0;
    int n_expired   = 0;
    int n_nulls     = 0;

    // Stimulus-side view of the settings and time
    int unsigned gen_delay    = DELAY_RST;
    int unsigned gen_interval = INTERVAL_RST;
    int unsigned gen_life     = LIFETIME_RST;
    logic [31:0] gen_now      = 32'd1000;

    int burst_left  = 1;
    int gap_left    = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_phase = 0;

    // Advance the repeat engine; returns 1 when a repeat is due at now.
    function automatic bit advance_repeat(logic [31:0] now);
        if (rpt_active) begin
            if ({1'b0, now} >= {1'b0, last_rpt_ms} + {17'b0, interval_ms}) begin
                last_rpt_ms = now;
                return 1'b1;
            end
        end
        else if (key_held != '0) begin
            if ({1'b0, now} >= {1'b0, press_ms} + {17'b0, delay_ms}) begin
                last_rpt_ms = now;
                rpt_active  = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic out_item_t predict_key_result(in_item_t it);
        out_item_t r;
        r = '0;
        if (it.opcode == OP_EVENT) begin
            r.out_class = OUT_PASS;
            r.out_code  = it.event_code;
            r.out_arg   = it.event_arg;
            r.out_stamp = it.event_stamp;
            if ({1'b0, it.event_stamp} + {17'b0, lifetime_ms} > {1'b0, it.now_ms}) begin
                r.status = ST_DELIVERED;
                if (it.event_class == CLS_KEY_DOWN) begin
                    key_held   = it.event_arg;
                    press_ms   = it.now_ms;
                    rpt_active = 1'b0;
                end
                else if (it.event_class == CLS_KEY_UP) begin
                    key_held   = '0;
                    rpt_active = 1'b0;
                end
                else if (advance_repeat(it.now_ms)) begin
                    r.push_repeat = 1'b1;
                    r.push_arg    = key_held;
                    r.push_stamp  = it.now_ms;
                    n_pushes++;
                end
            end
            else begin
                r.status = ST_EXPIRED;
                n_expired++;
            end
        end
        else begin
            if (advance_repeat(it.now_ms)) begin
                r.status    = ST_DELIVERED;
                r.out_class = OUT_REPEAT;
                r.out_arg   = key_held;
                n_repeats++;
            end
            else begin
                r.status    = ST_NONE;
                r.out_class = OUT_NULL;
                n_nulls++;
            end
            r.out_stamp = it.now_ms;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item, expected none actual %h", $time, got);
            err_count++;
        end
        else begin
            want = expected_results.pop_front();
            check_field("status",      want.status,      got.status);
            check_field("out_class",   want.out_class,   got.out_class);
            check_field("out_code",    want.out_code,    got.out_code);
            check_field("out_arg",     want.out_arg,     got.out_arg);
            check_field("out_stamp",   want.out_stamp,   got.out_stamp);
            check_field("push_repeat", want.push_repeat, got.push_repeat);
            check_field("push_arg",    want.push_arg,    got.push_arg);
            check_field("push_stamp",  want.push_stamp,  got.push_stamp);
        end
    endtask

    // Driver: bursts of random length, random gaps, some long gapless runs
    always @(posedge clk or negedge rst_n)
    begin
        bit send_next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_key_result(in_data));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                send_next = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_items.size() > 0)
                    send_next = 1'b1;
                if (send_next)
                begin
                    in_data <= pending_items.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(40, 150);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 8);
                        end
                    end
                end
                in_valid <= send_next;
            end
        end
    end

    // Monitor: checks results, stalls in changing modes
    always @(posedge clk or negedge rst_n)
    begin
        bit ready_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 80);
            end
            else
                mode_left--;
            stall_phase++;
            case (stall_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = $urandom_range(0, 1);
                2:       ready_next = (stall_phase % 3) == 0;
                default: ready_next = $urandom_range(0, 7) != 0;
            endcase
            out_ready <= ready_next;
        end
    end

    function automatic in_item_t mk_item(logic op, logic [1:0] cls, logic [15:0] code,
                                         logic [15:0] arg, logic [31:0] stamp,
                                         logic [31:0] now);
        in_item_t it;
        it.opcode      = op;
        it.event_class = cls;
        it.event_code  = code;
        it.event_arg   = arg;
        it.event_stamp = stamp;
        it.now_ms      = now;
        return it;
    endfunction

    task automatic queue_item(in_item_t it);
        pending_items.push_back(it);
        n_generated++;
    endtask

    // Wait until every queued item is accepted and every result is back.
    task automatic wait_idle();
        while (n_accepted != n_generated || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(logic [15:0] d_val, logic [15:0] i_val, logic [15:0] l_val);
        logic [15:0] vals [0:2];
        logic [1:0]  idx  [0:2];
        vals[0] = d_val;
        vals[1] = i_val;
        vals[2] = l_val;
        idx[0]  = REG_DELAY;
        idx[1]  = REG_INTERVAL;
        idx[2]  = REG_LIFETIME;
        @(posedge clk);
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (cfg_index)
                REG_DELAY:    delay_ms    = cfg_data;
                REG_INTERVAL: interval_ms = cfg_data;
                REG_LIFETIME: lifetime_ms = cfg_data;
                default:      ;
            endcase
        end
        cfg_valid <= 1'b0;
        gen_delay    = d_val;
        gen_interval = i_val;
        gen_life     = l_val;
        n_settings++;
    endtask

    // Time step, biased toward the interval and delay boundaries
    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return gen_interval;
            3:       return (gen_interval > 0) ? gen_interval - 1 : 0;
            4:       return gen_interval + 1;
            5:       return $urandom_range(0, 2 * gen_interval + 2);
            6:       return gen_delay;
            7:       return $urandom_range(0, gen_delay + gen_interval + 2);
            8:       return $urandom_range(0, 8);
            default: return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
        endcase
    endfunction

    // Event age, biased toward the lifetime boundary; negative ages too
    function automatic logic [31:0] pick_age();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return $urandom_range(0, 5);
            2:       return gen_life - 1;
            3:       return gen_life;
            4:       return gen_life + 1;
            5:       return $urandom_range(0, gen_life + 10);
            6:       return 32'd0 - $urandom_range(1, 10);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return $urandom_range(1, 16'hFFFE);
        endcase
    endfunction

    task automatic run_random_phase(int n_items);
        int          count;
        int          len;
        logic [31:0] t_press;
        logic [1:0]  cls;
        count = 0;
        while (count < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // noise: any field combination
                queue_item(mk_item($urandom_range(0, 1), $urandom_range(0, 3), $urandom,
                                   $urandom, $urandom, $urandom));
                count++;
            end
            else
            begin
                gen_now += pick_step();
                t_press  = gen_now;
                queue_item(mk_item(OP_EVENT, CLS_KEY_DOWN, $urandom, pick_key(),
                                   gen_now - $urandom_range(0, 3), gen_now));
                count++;
                len = $urandom_range(2, 14);
                for (int j = 0; j < len; j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        gen_now = t_press + gen_delay - $urandom_range(0, 1);
                    else
                        gen_now += pick_step();
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5:
                            queue_item(mk_item(OP_POLL, $urandom_range(0, 3), $urandom,
                                               $urandom, $urandom, gen_now));
                        6, 7, 8:
                        begin
                            cls = ($urandom_range(0, 3) == 0) ? CLS_RESERVED : CLS_OTHER;
                            queue_item(mk_item(OP_EVENT, cls, $urandom, $urandom,
                                               gen_now - pick_age(), gen_now));
                        end
                        default:
                        begin
                            cls = $urandom_range(0, 1) ? CLS_KEY_DOWN : CLS_KEY_UP;
                            queue_item(mk_item(OP_EVENT, cls, $urandom, pick_key(),
                                               gen_now - pick_age(), gen_now));
                            if (cls == CLS_KEY_DOWN)
                                t_press = gen_now;
                        end
                    endcase
                    count++;
                end
                gen_now += pick_step();
                queue_item(mk_item(OP_EVENT, CLS_KEY_UP, $urandom, $urandom,
                                   ($urandom_range(0, 6) != 0) ? gen_now : gen_now - pick_age(),
                                   gen_now));
                count++;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset settings (delay 500, interval 50, lifetime 3000)
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd1000));
        queue_item(mk_item(OP_EVENT, CLS_OTHER,    16'h0001, 16'h0002, 32'd1000, 32'd1000));
        queue_item(mk_item(OP_EVENT, CLS_KEY_DOWN, 16'h0010, 16'h0041, 32'd1000, 32'd1000));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd1499));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd1500));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd1549));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd1550));
        queue_item(mk_item(OP_EVENT, CLS_OTHER,    16'hFFFF, 16'hFFFF, 32'd1600, 32'd1600));
        // aged out exactly at the lifetime: no state change
        queue_item(mk_item(OP_EVENT, CLS_KEY_UP,   16'h0020, 16'h0041, 32'd0,    32'd3000));
        queue_item(mk_item(OP_EVENT, CLS_KEY_DOWN, 16'h0020, 16'h0007, 32'd0,    32'd3001));
        // one ms short of the lifetime, reserved class acts as other
        queue_item(mk_item(OP_EVENT, CLS_RESERVED, 16'h0000, 16'h0000, 32'd1,    32'd3000));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd3049));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd3050));
        queue_item(mk_item(OP_EVENT, CLS_KEY_UP,   16'h0011, 16'h0041, 32'd3100, 32'd3100));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd4000));
        // key code zero holds nothing
        queue_item(mk_item(OP_EVENT, CLS_KEY_DOWN, 16'h0010, 16'h0000, 32'd4000, 32'd4000));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd9000));
        // stamp and time at the top of the range: sums must not wrap
        queue_item(mk_item(OP_EVENT, CLS_KEY_DOWN, 16'h0010, 16'hFFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
        queue_item(mk_item(OP_POLL,  CLS_RESERVED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                           32'd0));
        // second key down while repeating restarts the delay
        queue_item(mk_item(OP_EVENT, CLS_KEY_DOWN, 16'h0010, 16'h1234, 32'd5000, 32'd5000));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd5500));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd5550));
        queue_item(mk_item(OP_EVENT, CLS_KEY_DOWN, 16'h0010, 16'h5678, 32'd5560, 32'd5560));
        queue_item(mk_item(OP_POLL,  CLS_OTHER,    16'h0000, 16'h0000, 32'd0,    32'd5600));
        wait_idle();

        gen_now = 32'd10000;
        program_regs(16'h0000, 16'h0000, 16'h0000);
        run_random_phase(80);
        wait_idle();

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_phase(80);
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            program_regs($urandom_range(0, 60), $urandom_range(0, 25), $urandom_range(1, 300));
            run_random_phase(115);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("Checked %0d items under %0d register settings", n_accepted, n_settings);
        $display("  repeats %0d, pushes %0d, expired %0d, null polls %0d",
                 n_repeats, n_pushes, n_expired, n_nulls);
        if (err_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
